>>> rtl/core/sssl_pkg.sv
// shared types and constants of the sparse stack snapshot lookup
`default_nettype none

package sssl_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // request kinds
    localparam logic [1:0] FN_LOAD    = 2'd0;
    localparam logic [1:0] FN_CLEAR   = 2'd1;
    localparam logic [1:0] FN_READ    = 2'd2;
    localparam logic [1:0] FN_RECOVER = 2'd3;

    // near-stack window and frame step
    localparam logic [63:0] NEAR_BELOW = 64'd1024;
    localparam logic [63:0] NEAR_SPAN  = 64'd16778240;
    localparam logic [31:0] FRAME_STEP = 32'd8;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] address;
        logic [31:0] frame_ptr;
        logic [31:0] stack_ptr;
        logic [15:0] entry_offset;
        logic [31:0] entry_value;
    } item_t;

    typedef struct packed {
        logic [31:0] value;
        logic        found;
        logic [31:0] new_frame_ptr;
        logic [31:0] new_stack_ptr;
        logic        in_stack;
        logic        table_full;
    } res_t;

    // table port: one write and one read per cycle
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [15:0]      wr_offset;
        logic [31:0]      wr_word;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
    } tbl_req_t;

    typedef struct packed {
        logic [15:0] offset;
        logic [31:0] word;
    } tbl_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/sssl_table.sv
// offset and word memories of the snapshot table, registered read
`default_nettype none

module sssl_table (
    input  wire                aclk,
    input  sssl_pkg::tbl_req_t tbl_req,
    output sssl_pkg::tbl_rsp_t tbl_rsp
);
    import sssl_pkg::*;

    logic [15:0] offset_mem [TABLE_DEPTH];
    logic [31:0] word_mem   [TABLE_DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (tbl_req.wr_en) begin
            offset_mem[tbl_req.wr_idx] <= tbl_req.wr_offset;
            word_mem[tbl_req.wr_idx]   <= tbl_req.wr_word;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (tbl_req.rd_en) begin
            tbl_rsp.offset <= offset_mem[tbl_req.rd_idx];
            tbl_rsp.word   <= word_mem[tbl_req.rd_idx];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sssl_engine.sv
// request sequencer: table append, clear and lower-bound binary search
`default_nettype none

module sssl_engine (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                req_valid,
    output logic               req_ready,
    input  sssl_pkg::item_t    req_item,
    input  wire [63:0]         stack_top,
    output logic               res_valid,
    input  wire                res_ready,
    output sssl_pkg::res_t     res,
    output sssl_pkg::tbl_req_t tbl_req,
    input  sssl_pkg::tbl_rsp_t tbl_rsp
);
    import sssl_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_PROBE = 3'd2;
    localparam logic [2:0] ST_HIT   = 3'd3;
    localparam logic [2:0] ST_NEXT  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       func_reg, func_next;
    logic [31:0]      fp_reg, fp_next;
    logic [31:0]      sp_reg, sp_next;
    logic [63:0]      diff_reg, diff_next;
    logic [15:0]      key_reg, key_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [31:0]      word_i_reg, word_i_next;
    logic [15:0]      off_i_reg, off_i_next;
    res_t             res_reg, res_next;

    logic             accept;
    logic [CNT_W:0]   sum_cur;
    logic [CNT_W-1:0] mid_cur;
    logic [CNT_W-1:0] lo_probe, hi_probe;
    logic [CNT_W:0]   sum_probe;
    logic [CNT_W-1:0] mid_probe;
    logic [CNT_W-1:0] lo_plus1;
    logic [63:0]      base_addr;
    logic [63:0]      near_diff;
    logic             is_recover;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // current probe point and the narrowed range after its compare
    assign sum_cur   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_cur   = sum_cur[CNT_W:1];
    assign lo_probe  = (tbl_rsp.offset < key_reg) ? mid_cur + CNT_W'(1) : lo_reg;
    assign hi_probe  = (tbl_rsp.offset < key_reg) ? hi_reg : mid_cur;
    assign sum_probe = {1'b0, lo_probe} + {1'b0, hi_probe};
    assign mid_probe = sum_probe[CNT_W:1];
    assign lo_plus1  = lo_reg + CNT_W'(1);

    assign base_addr  = (req_item.func == FN_READ) ? req_item.address
                                                   : {32'd0, req_item.frame_ptr};
    assign near_diff  = diff_reg + NEAR_BELOW;
    assign is_recover = (func_reg == FN_RECOVER);

    // sequencer; writes happen only in idle and reads only after it, so
    // the two table ports never touch the same entry in one cycle
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        func_next   = func_reg;
        fp_next     = fp_reg;
        sp_next     = sp_reg;
        diff_next   = diff_reg;
        key_next    = key_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        word_i_next = word_i_reg;
        off_i_next  = off_i_reg;
        res_next    = res_reg;
        tbl_req     = '0;
        tbl_req.wr_idx    = count_reg[IDX_W-1:0];
        tbl_req.wr_offset = req_item.entry_offset;
        tbl_req.wr_word   = req_item.entry_value;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    func_next = req_item.func;
                    fp_next   = req_item.frame_ptr;
                    sp_next   = req_item.stack_ptr;
                    diff_next = base_addr - stack_top;
                    res_next  = '0;
                    case (req_item.func)
                        FN_LOAD: begin
                            if (count_reg < CNT_W'(TABLE_DEPTH)) begin
                                tbl_req.wr_en = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                            end else begin
                                res_next.table_full = 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        FN_CLEAR: begin
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_START;
                        end
                    endcase
                end
            end
            ST_START: begin
                // miss defaults, then the first probe at the middle
                res_next = '0;
                if (is_recover) begin
                    res_next.new_frame_ptr = fp_reg;
                    res_next.new_stack_ptr = sp_reg;
                end else begin
                    res_next.in_stack = (near_diff < NEAR_SPAN);
                end
                key_next = diff_reg[17:2];
                lo_next  = '0;
                hi_next  = count_reg;
                if (diff_reg[31] || (count_reg == '0)) begin
                    state_next = ST_DONE;
                end else begin
                    tbl_req.rd_en  = 1'b1;
                    tbl_req.rd_idx = count_reg[IDX_W:1];
                    state_next     = ST_PROBE;
                end
            end
            ST_PROBE: begin
                lo_next = lo_probe;
                hi_next = hi_probe;
                if (lo_probe < hi_probe) begin
                    tbl_req.rd_en  = 1'b1;
                    tbl_req.rd_idx = mid_probe[IDX_W-1:0];
                end else if (lo_probe < count_reg) begin
                    tbl_req.rd_en  = 1'b1;
                    tbl_req.rd_idx = lo_probe[IDX_W-1:0];
                    state_next     = ST_HIT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_HIT: begin
                state_next = ST_DONE;
                if (tbl_rsp.offset == key_reg) begin
                    if (!is_recover) begin
                        res_next.value = tbl_rsp.word;
                        res_next.found = 1'b1;
                    end else if (lo_plus1 < count_reg) begin
                        // fetch the following entry for the return address
                        word_i_next    = tbl_rsp.word;
                        off_i_next     = tbl_rsp.offset;
                        tbl_req.rd_en  = 1'b1;
                        tbl_req.rd_idx = lo_plus1[IDX_W-1:0];
                        state_next     = ST_NEXT;
                    end
                end
            end
            ST_NEXT: begin
                if ({1'b0, tbl_rsp.offset} == ({1'b0, off_i_reg} + 17'd1)) begin
                    res_next.value         = tbl_rsp.word;
                    res_next.found         = 1'b1;
                    res_next.new_frame_ptr = word_i_reg;
                    res_next.new_stack_ptr = fp_reg + FRAME_STEP;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        fp_reg     <= fp_next;
        sp_reg     <= sp_next;
        diff_reg   <= diff_next;
        key_reg    <= key_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        word_i_reg <= word_i_next;
        off_i_reg  <= off_i_next;
        res_reg    <= res_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/sparse_stack_snapshot_lookup.sv
// top level of the sparse stack snapshot lookup
`default_nettype none

// Sparse stack snapshot lookup. Requests are handled one at a time. A read
// or a frame recovery runs a lower-bound binary search over the n table
// entries (up to 1024 in a full table), one probe of the single-read-port
// table memory per cycle, and a recovery adds the fetch of the following
// entry. A result is held in an output register, so the next request is
// taken while it waits. The table has no reset of its contents; the entry
// count is cleared by reset and by clear requests.
module sparse_stack_snapshot_lookup (
    input  wire          aclk,
    input  wire          aresetn,
    // stack top register
    input  wire          cfg_wen,
    input  wire  [63:0]  cfg_wdata,
    // request channel
    input  wire          s_tvalid,
    output logic         s_tready,
    // address, frame_ptr, stack_ptr, entry_offset, entry_value
    input  wire  [175:0] s_tdata,
    // func
    input  wire  [1:0]   s_tuser,
    // result channel
    output logic         m_tvalid,
    input  wire          m_tready,
    // value, new_frame_ptr, new_stack_ptr
    output logic [95:0]  m_tdata,
    // found, in_stack, table_full
    output logic [2:0]   m_tuser
);
    import sssl_pkg::*;

    logic [63:0] stack_top_reg;
    item_t       item;
    res_t        eng_res;
    logic        eng_res_valid;
    logic        eng_res_ready;
    tbl_req_t    tbl_req;
    tbl_rsp_t    tbl_rsp;
    logic        m_valid_reg;
    res_t        out_reg;

    // stack top register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_top_reg <= '0;
        end else if (cfg_wen) begin
            stack_top_reg <= cfg_wdata;
        end
    end

    // unpack the request
    assign item.func         = s_tuser;
    assign item.address      = s_tdata[63:0];
    assign item.frame_ptr    = s_tdata[95:64];
    assign item.stack_ptr    = s_tdata[127:96];
    assign item.entry_offset = s_tdata[143:128];
    assign item.entry_value  = s_tdata[175:144];

    sssl_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_item  (item),
        .stack_top (stack_top_reg),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .res       (eng_res),
        .tbl_req   (tbl_req),
        .tbl_rsp   (tbl_rsp)
    );

    sssl_table u_table (
        .aclk    (aclk),
        .tbl_req (tbl_req),
        .tbl_rsp (tbl_rsp)
    );

    // output register
    assign eng_res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (eng_res_ready) begin
            m_valid_reg <= eng_res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_res_ready && eng_res_valid) begin
            out_reg <= eng_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_reg.new_stack_ptr, out_reg.new_frame_ptr, out_reg.value};
    assign m_tuser  = {out_reg.table_full, out_reg.in_stack, out_reg.found};

endmodule

`default_nettype wire

>>> rtl/core/sssl_checker.sv
// port-level checks of the sparse stack snapshot lookup and their bind
`default_nettype none

module sssl_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [95:0] m_tdata,
    input wire [2:0]  m_tuser
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one request at a time: no request taken right after another
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // a dropped load never reports a hit or a near address
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> !m_tuser[0] && !m_tuser[1])
        else $error("full flag with other flags");

    // a miss returns a zero word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == 32'd0)
        else $error("nonzero value without hit");

endmodule

bind sparse_stack_snapshot_lookup sssl_checker u_sssl_checker (.*);

`default_nettype wire
